// ===== rtl/dfr_pkg.sv =====
`default_nettype none

package dfr_pkg;

    localparam int HDR_BYTES = 40;
    localparam int HDR_AW = $clog2(HDR_BYTES + 1);
    localparam int CFG_W = 17;
    localparam int LEN_W = 16;
    localparam logic [CFG_W-1:0] MAX_PKT_RESET = 17'd65575;
    localparam logic [3:0] IP_VERSION = 4'd6;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_VERSION = 2'd1,
        ST_SIZE    = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        t_status    status;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    typedef enum logic [3:0] {
        S_HDR     = 4'b0001,
        S_REPLAY  = 4'b0010,
        S_PAYLOAD = 4'b0100,
        S_HALT    = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/dfr_front.sv =====
`default_nettype none

module dfr_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [7:0]                i_data_byte,
    input  wire logic [dfr_pkg::CFG_W-1:0] i_size_limit,
    input  wire logic                      i_full,
    output dfr_pkg::t_push                 o_push
);

    localparam int AW = dfr_pkg::HDR_AW;
    localparam int LW = dfr_pkg::LEN_W;
    localparam int CW = dfr_pkg::CFG_W;

    dfr_pkg::t_state r_state, n_state;
    logic [AW-1:0] r_count, n_count;
    logic [AW-1:0] r_rd_addr, n_rd_addr;
    logic [AW-1:0] r_push_idx, n_push_idx;
    logic          r_pend, n_pend;
    logic [7:0]    r_rd_data;
    logic [3:0]    r_ver, n_ver;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_rem, n_rem;
    logic [7:0]    r_mem [dfr_pkg::HDR_BYTES];

    logic          accept;
    logic          hdr_last;
    logic          size_bad;
    logic [CW-1:0] total;
    logic          issue;
    logic          rp_push;
    logic [LW-1:0] rem_base;
    logic [LW-1:0] rem_dec;

    function automatic logic hdr_push_end();
        return r_push_idx == AW'(dfr_pkg::HDR_BYTES - 1);
    endfunction

    assign accept   = i_valid && o_ready;
    assign hdr_last = (r_count == AW'(dfr_pkg::HDR_BYTES - 1));
    assign total    = CW'(dfr_pkg::HDR_BYTES) + CW'(r_len);
    assign size_bad = (total > i_size_limit);
    assign rp_push  = (r_state == dfr_pkg::S_REPLAY) && r_pend && !i_full;
    assign issue    = (r_state == dfr_pkg::S_REPLAY)
                      && (r_rd_addr != AW'(dfr_pkg::HDR_BYTES))
                      && (!r_pend || rp_push);
    assign rem_base = (r_rem == '0) ? LW'(1) : r_rem;
    assign rem_dec  = rem_base - LW'(1);

    always_comb begin
        unique case (r_state)
            dfr_pkg::S_HDR, dfr_pkg::S_PAYLOAD: o_ready = !i_full;
            dfr_pkg::S_REPLAY:                  o_ready = 1'b0;
            default:                            o_ready = 1'b1;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_rd_addr  = r_rd_addr;
        n_push_idx = r_push_idx;
        n_pend     = r_pend;
        n_ver      = r_ver;
        n_len      = r_len;
        n_rem      = r_rem;
        o_push     = '0;
        unique case (r_state)
            dfr_pkg::S_HDR: begin
                if (accept) begin
                    n_count = r_count + AW'(1);
                    if (r_count == AW'(0)) begin
                        n_ver = i_data_byte[7:4];
                    end
                    if (r_count == AW'(4)) begin
                        n_len[15:8] = i_data_byte;
                    end
                    if (r_count == AW'(5)) begin
                        n_len[7:0] = i_data_byte;
                    end
                    if (hdr_last) begin
                        n_count = '0;
                        if (r_ver != dfr_pkg::IP_VERSION) begin
                            n_state            = dfr_pkg::S_HALT;
                            o_push.valid       = 1'b1;
                            o_push.cmd.last    = 1'b1;
                            o_push.cmd.status  = dfr_pkg::ST_VERSION;
                        end else if (size_bad) begin
                            n_state            = dfr_pkg::S_HALT;
                            o_push.valid       = 1'b1;
                            o_push.cmd.last    = 1'b1;
                            o_push.cmd.status  = dfr_pkg::ST_SIZE;
                        end else begin
                            n_state    = dfr_pkg::S_REPLAY;
                            n_rd_addr  = '0;
                            n_push_idx = '0;
                            n_pend     = 1'b0;
                            n_rem      = r_len;
                        end
                    end
                end
            end
            dfr_pkg::S_REPLAY: begin
                if (issue) begin
                    n_rd_addr = r_rd_addr + AW'(1);
                end
                if (issue) begin
                    n_pend = 1'b1;
                end else if (rp_push) begin
                    n_pend = 1'b0;
                end
                if (rp_push) begin
                    o_push.valid      = 1'b1;
                    o_push.cmd.data   = r_rd_data;
                    o_push.cmd.status = dfr_pkg::ST_OK;
                    o_push.cmd.last   = hdr_push_end() && (r_len == '0);
                    n_push_idx        = r_push_idx + AW'(1);
                    if (hdr_push_end()) begin
                        n_state = (r_len == '0) ? dfr_pkg::S_HDR : dfr_pkg::S_PAYLOAD;
                    end
                end
            end
            dfr_pkg::S_PAYLOAD: begin
                if (accept) begin
                    n_rem             = rem_dec;
                    o_push.valid      = 1'b1;
                    o_push.cmd.data   = i_data_byte;
                    o_push.cmd.status = dfr_pkg::ST_OK;
                    o_push.cmd.last   = (rem_dec == '0);
                    if (rem_dec == '0) begin
                        n_state = dfr_pkg::S_HDR;
                    end
                end
            end
            default: begin
                n_state = dfr_pkg::S_HALT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= dfr_pkg::S_HDR;
            r_count    <= '0;
            r_rd_addr  <= '0;
            r_push_idx <= '0;
            r_pend     <= 1'b0;
            r_rem      <= '0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_rd_addr  <= n_rd_addr;
            r_push_idx <= n_push_idx;
            r_pend     <= n_pend;
            r_rem      <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ver <= n_ver;
        r_len <= n_len;
    end

    // header store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (accept && (r_state == dfr_pkg::S_HDR)) begin
            r_mem[r_count] <= i_data_byte;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_rd_addr];
        end
    end

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dfr_pkg::S_HALT) |-> !o_push.valid)
        else $error("item pushed while halted");

    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.valid && (o_push.cmd.status != dfr_pkg::ST_OK))
        |=> (r_state == dfr_pkg::S_HALT))
        else $error("error item without halt");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= AW'(dfr_pkg::HDR_BYTES - 1))
        else $error("header count out of range");

endmodule

`default_nettype wire

// ===== rtl/dfr_back.sv =====
`default_nettype none

module dfr_back #(
    parameter int QUEUE_DEPTH = dfr_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire dfr_pkg::t_push i_push,
    output logic                o_full,
    output logic                o_valid,
    input  wire logic           i_ready,
    output dfr_pkg::t_cmd       o_res
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNW = $clog2(QUEUE_DEPTH + 1);

    dfr_pkg::t_cmd r_q [QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNW-1:0] r_count, n_count;
    logic           r_out_valid, n_out_valid;
    dfr_pkg::t_cmd  r_out;

    logic pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_full  = (r_count == CNW'(QUEUE_DEPTH));
    assign pop     = (r_count != '0) && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    always_comb begin
        n_wr_ptr    = i_push.valid ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr    = pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count     = r_count + CNW'(i_push.valid) - CNW'(pop);
        n_out_valid = pop ? 1'b1 : (i_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_q[r_wr_ptr] <= i_push.cmd;
        end
        if (pop) begin
            r_out <= r_q[r_rd_ptr];
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> !o_full)
        else $error("push into full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNW'(QUEUE_DEPTH))
        else $error("queue count above depth");

endmodule

`default_nettype wire

// ===== rtl/ipv6_stream_deframer.sv =====
`default_nettype none

// channel   direction  handshake           payload
// input     in         i_valid / o_ready   i_data_byte
// output    out        o_valid / i_ready   o_out_byte, o_end_of_packet, o_status
// config    in         i_cfg_we            i_cfg_wdata (packet size limit)
//
// header and payload bytes are taken one per cycle while o_ready is high
// a last header byte that passes both checks starts a replay of the 40-byte
// header store, one read port, during which no input item is taken
// output queue full holds off input; an error result halts the block until reset
// synchronous active-low reset; the size limit resets to 65575

module ipv6_stream_deframer #(
    parameter int QUEUE_DEPTH = dfr_pkg::QUEUE_DEPTH
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [7:0]                i_data_byte,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [7:0]                     o_out_byte,
    output logic                           o_end_of_packet,
    output logic [1:0]                     o_status,
    input  wire logic                      i_cfg_we,
    input  wire logic [dfr_pkg::CFG_W-1:0] i_cfg_wdata
);

    logic [dfr_pkg::CFG_W-1:0] r_size_limit;
    dfr_pkg::t_push            push;
    logic                      full;
    dfr_pkg::t_cmd             res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_limit <= dfr_pkg::MAX_PKT_RESET;
        end else if (i_cfg_we) begin
            r_size_limit <= i_cfg_wdata;
        end
    end

    dfr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_size_limit (r_size_limit),
        .i_full       (full),
        .o_push       (push)
    );

    dfr_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (res)
    );

    assign o_out_byte      = res.data;
    assign o_end_of_packet = res.last;
    assign o_status        = res.status;

endmodule

`default_nettype wire

// ===== dv/tb_ipv6_stream_deframer.sv =====
`default_nettype none

module tb_ipv6_stream_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CFG_W     = dfr_pkg::CFG_W;
    localparam int HDR_BYTES = dfr_pkg::HDR_BYTES;
    localparam int LEN_W     = dfr_pkg::LEN_W;

    typedef enum logic [1:0] {
        DF_HEADER,
        DF_PAYLOAD,
        DF_HALTED
    } t_deframe_phase;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    logic [7:0]       i_data_byte;
    logic             o_valid;
    logic             i_ready;
    logic [7:0]       o_out_byte;
    logic             o_end_of_packet;
    logic [1:0]       o_status;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    // predicted packet stream and the deframer state behind it
    dfr_pkg::t_cmd    deframed_q[$];
    logic [7:0]       hdr_mirror[HDR_BYTES];
    int unsigned      hdr_fill = 0;
    logic [LEN_W-1:0] payload_left = '0;
    t_deframe_phase   df_phase = DF_HEADER;
    logic [CFG_W-1:0] max_size_cfg = dfr_pkg::MAX_PKT_RESET;

    int               mismatches = 0;
    int               bytes_sent = 0;
    bit               quiet = 1'b0;
    bit               hold_pending = 1'b0;
    int               hold_cycles = 0;
    int               stall_left = 0;
    dfr_pkg::t_cmd    got;

    ipv6_stream_deframer u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_byte     (o_out_byte),
        .o_end_of_packet(o_end_of_packet),
        .o_status       (o_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void push_result(logic [7:0] d, logic l, dfr_pkg::t_status s);
        dfr_pkg::t_cmd c;
        c.data = d;
        c.last = l;
        c.status = s;
        deframed_q.push_back(c);
    endfunction

    function automatic void deframe_byte(logic [7:0] b);
        int unsigned len;
        int i;
        case (df_phase)
            DF_HEADER: begin
                hdr_mirror[hdr_fill] = b;
                hdr_fill++;
                if (hdr_fill == HDR_BYTES) begin
                    hdr_fill = 0;
                    len = 32'({hdr_mirror[4], hdr_mirror[5]});
                    if (hdr_mirror[0][7:4] != dfr_pkg::IP_VERSION) begin
                        push_result(8'h00, 1'b1, dfr_pkg::ST_VERSION);
                        df_phase = DF_HALTED;
                    end else if (HDR_BYTES + len > max_size_cfg) begin
                        push_result(8'h00, 1'b1, dfr_pkg::ST_SIZE);
                        df_phase = DF_HALTED;
                    end else begin
                        for (i = 0; i < HDR_BYTES; i++) begin
                            push_result(hdr_mirror[i], len == 0 && i == HDR_BYTES - 1,
                                        dfr_pkg::ST_OK);
                        end
                        payload_left = len[LEN_W-1:0];
                        df_phase = (len == 0) ? DF_HEADER : DF_PAYLOAD;
                    end
                end
            end
            DF_PAYLOAD: begin
                payload_left--;
                push_result(b, payload_left == 0, dfr_pkg::ST_OK);
                if (payload_left == 0) begin
                    df_phase = DF_HEADER;
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, int unsigned exp, int unsigned act);
        $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, exp, act);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                deframe_byte(i_data_byte);
            end
            if (o_valid && i_ready) begin
                if (deframed_q.size() == 0) begin
                    report_mismatch("item with nothing due, out_byte", 0, 32'(o_out_byte));
                end else begin
                    got = deframed_q.pop_front();
                    if (o_out_byte !== got.data) begin
                        report_mismatch("out_byte", 32'(got.data), 32'(o_out_byte));
                    end
                    if (o_end_of_packet !== got.last) begin
                        report_mismatch("end_of_packet", 32'(got.last),
                                        32'(o_end_of_packet));
                    end
                    if (o_status !== got.status) begin
                        report_mismatch("status", 32'(got.status), 32'(o_status));
                    end
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 60);
    endfunction

    // receiver side: random stalls, plus a long hold-off on request
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_pending) begin
                i_ready <= 1'b0;
                repeat (hold_cycles) @(negedge i_clk);
                hold_pending = 1'b0;
                i_ready <= 1'b1;
            end else if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 9) < 2) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        bytes_sent++;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // fill < 0 gives random content, otherwise every free byte is fill
    task automatic send_header(logic [3:0] ver, logic [15:0] len, int fill);
        int k;
        logic [7:0] hb;
        for (k = 0; k < HDR_BYTES; k++) begin
            hb = (fill < 0) ? 8'($urandom) : 8'(fill);
            if (k == 0) hb[7:4] = ver;
            if (k == 4) hb = len[15:8];
            if (k == 5) hb = len[7:0];
            send_byte(hb);
        end
    endtask

    task automatic send_packet(logic [15:0] len, int fill);
        int k;
        send_header(dfr_pkg::IP_VERSION, len, fill);
        for (k = 0; k < len; k++) begin
            send_byte((fill < 0) ? 8'($urandom) : 8'(fill));
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (deframed_q.size() != 0) @(negedge i_clk);
        repeat (48) @(negedge i_clk);
    endtask

    task automatic write_max_size(logic [CFG_W-1:0] v);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        max_size_cfg = v;
    endtask

    function automatic logic [15:0] pick_len();
        int r;
        int len;
        int room;
        r = $urandom_range(0, 99);
        if (r < 20) len = 0;
        else if (r < 80) len = $urandom_range(1, 8);
        else if (r < 95) len = $urandom_range(9, 64);
        else len = $urandom_range(65, 100);
        room = int'(max_size_cfg) - HDR_BYTES;
        if (len > room) len = room;
        return 16'(len);
    endfunction

    function automatic logic [CFG_W-1:0] pick_max_size();
        case ($urandom_range(0, 3))
            0: return CFG_W'($urandom_range(40, 120));
            1: return CFG_W'($urandom_range(121, 2000));
            2: return CFG_W'($urandom_range(2001, 131071));
            default: return $urandom_range(0, 1) ? 17'd131071 : dfr_pkg::MAX_PKT_RESET;
        endcase
    endfunction

    function automatic logic [3:0] pick_bad_version();
        int v;
        v = $urandom_range(0, 14);
        if (v >= dfr_pkg::IP_VERSION) v++;
        return 4'(v);
    endfunction

    task automatic test_directed_packets();
        send_packet(16'd3, 'hFF);
    endtask

    // packet size exactly at the limit passes
    task automatic test_size_boundary();
        write_max_size(17'd40);
        send_packet(16'd0, -1);
        write_max_size(17'd41);
        send_packet(16'd1, -1);
    endtask

    task automatic test_max_register();
        write_max_size(17'd131071);
        send_packet(16'd1, -1);
    endtask

    task automatic test_random_stream();
        int start;
        start = bytes_sent;
        while (bytes_sent - start < 40) begin
            if ($urandom_range(0, 3) == 0) begin
                write_max_size(pick_max_size());
            end
            quiet = ($urandom_range(0, 5) == 0);
            send_packet(pick_len(), -1);
        end
        quiet = 1'b0;
    endtask

    task automatic test_output_stall();
        quiet = 1'b1;
        hold_cycles = 300;
        hold_pending = 1'b1;
        send_packet(16'($urandom_range(1, 8)), -1);
        quiet = 1'b0;
    endtask

    // one failed check halts the block for the rest of the run
    task automatic test_halt_on_error();
        int c;
        case ($urandom_range(0, 3))
            0: begin
                send_header(pick_bad_version(), pick_len(), -1);
            end
            1: begin
                // both checks fail, version error wins
                write_max_size('0);
                send_header(pick_bad_version(), 16'($urandom), -1);
            end
            2: begin
                c = $urandom_range(40, 1000);
                write_max_size(CFG_W'(c));
                send_header(dfr_pkg::IP_VERSION, 16'(c - 39), -1);
            end
            default: begin
                write_max_size(17'd65574);
                send_header(dfr_pkg::IP_VERSION, 16'hFFFF, -1);
            end
        endcase
        repeat (4) send_byte(8'($urandom));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data_byte = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_packets();
        test_size_boundary();
        test_max_register();
        test_random_stream();
        test_output_stall();
        test_halt_on_error();

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
